FILE: src/fcn_pkg.sv
// shared types, commands, status codes and default sizes of the column normalizer
package fcn_pkg;

  // default sizes
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int STORE_DEPTH_DEF = 4096;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE    = 1'd1;

  // commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_BAD_SHAPE = 2'd3;

  // normalization modes
  localparam logic MODE_ZSCORE = 1'b0;
  localparam logic MODE_MINMAX = 1'b1;

  // request payload
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] sample_value;
  } in_t;

  // result payload
  typedef struct packed {
    logic signed [15:0] result_value;
    logic               is_last;
    logic [1:0]         status;
  } out_t;

endpackage

FILE: src/fcn_ram.sv
// generic simple dual-port ram with registered read
module fcn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/feature_column_normalizer_unit.sv
// column normalizer top level: element store, statistics sequencer and read path
//
//   channel | ports                           | payload
//   --------+---------------------------------+---------------------------
//   request | in_valid / in_stall / in_data   | fcn_pkg::in_t
//   result  | out_valid / out_stall / out_data| fcn_pkg::out_t
//   config  | cfg_we / cfg_index / cfg_wdata  | column_count, norm_mode
//
// load, clear, a refused read and a finish on an empty store are answered from the idle
// state; one result per request. a read with a zero column scale skips the divide, else
// it runs a 25-step serial divide on the single shared bit-serial divider.
// finish walks the store column by column, one pass in min-max mode and two in z-score
// mode, plus 17+CW divide steps for the mean, 32+CW for the variance, 16 square root
// steps, and a CW-step row count divide up front.
// reset is synchronous; the store needs no clearing. a stalled result holds the
// output register and the block takes no new request until that result leaves.
module feature_column_normalizer_unit #(
  parameter int MAX_COLUMNS = fcn_pkg::MAX_COLUMNS_DEF,
  parameter int STORE_DEPTH = fcn_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fcn_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fcn_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [fcn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcn_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int CLW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CEW  = $clog2(MAX_COLUMNS + 1);
  localparam int WAW  = CW + 7;
  localparam int SW   = 17 + CW;
  localparam int DW   = 32 + CW;
  localparam int DV   = (CW > 16) ? CW : 16;
  localparam int DCW  = $clog2(DW + 1);
  localparam int RNW  = 25;
  localparam int CFG_DATA_W_L = fcn_pkg::CFG_DATA_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FDIV  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_DIVM  = 4'd3;
  localparam logic [3:0] S_DIVV  = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_COLWR = 4'd6;
  localparam logic [3:0] S_RD1   = 4'd7;
  localparam logic [3:0] S_RDIV  = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0]              state_r;
  logic [CFG_DATA_W_L-1:0] colcnt_r;
  logic                    mode_r;
  logic [CW-1:0]           count_r;
  logic [AW-1:0]           pos_r;
  logic [CLW-1:0]          rcol_r;
  logic                    ready_r;
  logic                    out_valid_r;
  fcn_pkg::out_t           out_data_r;

  // pending result
  logic signed [15:0]      pres_r;
  logic                    plast_r;
  logic [1:0]              pstat_r;

  // statistics walk
  logic [CW-1:0]           rows_r;
  logic [CLW-1:0]          fc_r;
  logic [WAW-1:0]          wa_r;
  logic                    pass_r;
  logic                    first_r;
  logic                    v0_r;
  logic                    v1_r;
  logic signed [15:0]      x1_r;
  logic [31:0]             prod_r;
  logic signed [SW-1:0]    sum_r;
  logic [DW-1:0]           sq_r;
  logic signed [15:0]      lo_r;
  logic signed [15:0]      hi_r;
  logic signed [15:0]      mean_r;
  logic                    neg_r;
  logic signed [15:0]      off_r;
  logic [15:0]             scl_r;

  // serial divider
  logic [DW-1:0]           dq_r;
  logic [DV-1:0]           drem_r;
  logic [DV-1:0]           dden_r;
  logic [DCW-1:0]          dcnt_r;

  // square root
  logic [33:0]             sv_r;
  logic [33:0]             sres_r;
  logic [33:0]             sbit_r;

  // memory ports
  logic                    st_we;
  logic [AW-1:0]           st_raddr;
  logic [15:0]             st_rdata;
  logic                    cl_we;
  logic [31:0]             cl_rdata;

  logic                    out_free;
  logic                    accept;
  logic [CEW-1:0]          cols;
  logic signed [16:0]      d_sq;
  logic signed [33:0]      prod;
  logic [DV:0]             rem_sh;
  logic                    div_ge;
  logic [DV:0]             rem_nx;
  logic [SW-1:0]           abs_sum;
  logic [33:0]             s_trial;
  logic signed [15:0]      rx;
  logic signed [15:0]      roff;
  logic [15:0]             rscl;
  logic signed [16:0]      rdiff;
  logic [16:0]             rmag;
  logic [16:0]             lohi;
  logic                    wa_live;

  // effective column count
  always_comb begin
    if (colcnt_r == '0) begin
      cols = CEW'(1);
    end else if (32'(colcnt_r) > MAX_COLUMNS) begin
      cols = CEW'(MAX_COLUMNS);
    end else begin
      cols = CEW'(colcnt_r);
    end
  end

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // store ports
  assign st_we    = accept && (in_data.cmd == fcn_pkg::CMD_LOAD) &&
                    (count_r < CW'(STORE_DEPTH));
  assign st_raddr = (state_r == S_SCAN) ? wa_r[AW-1:0] : pos_r;
  assign cl_we    = (state_r == S_COLWR);
  assign wa_live  = wa_r < WAW'(count_r);

  fcn_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_data.sample_value),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  fcn_ram #(.WIDTH(32), .DEPTH(MAX_COLUMNS)) u_colstats (
    .clk   (clk),
    .we    (cl_we),
    .waddr (fc_r),
    .wdata ({off_r, scl_r}),
    .raddr (rcol_r),
    .rdata (cl_rdata)
  );

  // squared deviation of the element coming out of the store
  assign d_sq = {st_rdata[15], st_rdata} - {mean_r[15], mean_r};
  assign prod = d_sq * d_sq;

  // one restoring divide step
  assign rem_sh = {drem_r, dq_r[DW-1]};
  assign div_ge = rem_sh >= {1'b0, dden_r};
  assign rem_nx = div_ge ? (rem_sh - {1'b0, dden_r}) : rem_sh;

  assign abs_sum = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign s_trial = sres_r + sbit_r;
  assign lohi    = {hi_r[15], hi_r} - {lo_r[15], lo_r};

  // read path operands
  assign rx    = st_rdata;
  assign roff  = cl_rdata[31:16];
  assign rscl  = cl_rdata[15:0];
  assign rdiff = {rx[15], rx} - {roff[15], roff};
  assign rmag  = rdiff[16] ? 17'(-rdiff) : 17'(rdiff);

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      colcnt_r    <= CFG_DATA_W_L'(1);
      mode_r      <= fcn_pkg::MODE_ZSCORE;
      count_r     <= '0;
      pos_r       <= '0;
      rcol_r      <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // divider runs whenever steps remain
      if (dcnt_r != '0) begin
        dq_r   <= {dq_r[DW-2:0], div_ge};
        drem_r <= rem_nx[DV-1:0];
        dcnt_r <= dcnt_r - DCW'(1);
      end

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          fcn_pkg::REG_COLUMN_COUNT: begin
            colcnt_r <= cfg_wdata;
            ready_r  <= 1'b0;
          end
          fcn_pkg::REG_NORM_MODE: begin
            mode_r  <= cfg_wdata[0];
            ready_r <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.cmd)
              fcn_pkg::CMD_LOAD: begin
                out_valid_r <= 1'b1;
                out_data_r  <= '{result_value: '0, is_last: 1'b0,
                                 status: st_we ? fcn_pkg::ST_OK : fcn_pkg::ST_FULL};
                if (st_we) begin
                  count_r <= count_r + CW'(1);
                  ready_r <= 1'b0;
                end
              end
              fcn_pkg::CMD_FINISH: begin
                if (count_r == '0) begin
                  ready_r     <= 1'b0;
                  out_valid_r <= 1'b1;
                  out_data_r  <= '{result_value: '0, is_last: 1'b0,
                                   status: fcn_pkg::ST_BAD_SHAPE};
                end else begin
                  // row count and shape check through the divider
                  dq_r    <= DW'(count_r) << (DW - CW);
                  drem_r  <= '0;
                  dden_r  <= DV'(cols);
                  dcnt_r  <= DCW'(CW);
                  state_r <= S_FDIV;
                end
              end
              fcn_pkg::CMD_READ: begin
                if (!ready_r || count_r == '0 || CW'(pos_r) >= count_r) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= '{result_value: '0, is_last: 1'b0,
                                   status: fcn_pkg::ST_NOT_READY};
                end else begin
                  if (CW'(pos_r) + CW'(1) >= count_r) begin
                    plast_r <= 1'b1;
                    pos_r   <= '0;
                    rcol_r  <= '0;
                  end else begin
                    plast_r <= 1'b0;
                    pos_r   <= pos_r + AW'(1);
                    if (CEW'(rcol_r) == cols - CEW'(1)) begin
                      rcol_r <= '0;
                    end else begin
                      rcol_r <= rcol_r + CLW'(1);
                    end
                  end
                  pstat_r <= fcn_pkg::ST_OK;
                  state_r <= S_RD1;
                end
              end
              default: begin
                count_r     <= '0;
                pos_r       <= '0;
                rcol_r      <= '0;
                ready_r     <= 1'b0;
                out_valid_r <= 1'b1;
                out_data_r  <= '{result_value: '0, is_last: 1'b0, status: fcn_pkg::ST_OK};
              end
            endcase
          end
        end

        // rows known; reject a partial last row
        S_FDIV: begin
          if (dcnt_r == '0) begin
            if (drem_r != '0) begin
              ready_r <= 1'b0;
              pres_r  <= '0;
              plast_r <= 1'b0;
              pstat_r <= fcn_pkg::ST_BAD_SHAPE;
              state_r <= S_RESP;
            end else begin
              rows_r  <= dq_r[CW-1:0];
              fc_r    <= '0;
              wa_r    <= '0;
              pass_r  <= 1'b0;
              first_r <= 1'b1;
              sum_r   <= '0;
              sq_r    <= '0;
              state_r <= S_SCAN;
            end
          end
        end

        // walk one column: issue, square, accumulate or track min and max
        S_SCAN: begin
          v0_r <= wa_live;
          if (wa_live) begin
            wa_r <= wa_r + WAW'(cols);
          end
          v1_r   <= v0_r;
          x1_r   <= st_rdata;
          prod_r <= prod[31:0];
          if (v1_r) begin
            first_r <= 1'b0;
            if (pass_r) begin
              sq_r <= sq_r + DW'(prod_r);
            end else if (mode_r == fcn_pkg::MODE_ZSCORE) begin
              sum_r <= sum_r + SW'(x1_r);
            end else begin
              if (first_r || x1_r < lo_r) begin
                lo_r <= x1_r;
              end
              if (first_r || x1_r > hi_r) begin
                hi_r <= x1_r;
              end
            end
          end
          if (!wa_live && !v0_r && !v1_r) begin
            if (mode_r == fcn_pkg::MODE_MINMAX) begin
              off_r   <= lo_r;
              scl_r   <= lohi[15:0];
              state_r <= S_COLWR;
            end else if (!pass_r) begin
              neg_r   <= sum_r[SW-1];
              dq_r    <= DW'(abs_sum) << (DW - SW);
              drem_r  <= '0;
              dden_r  <= DV'(rows_r);
              dcnt_r  <= DCW'(SW);
              state_r <= S_DIVM;
            end else begin
              dq_r    <= sq_r;
              drem_r  <= '0;
              dden_r  <= DV'(rows_r);
              dcnt_r  <= DCW'(DW);
              state_r <= S_DIVV;
            end
          end
        end

        // mean done; second pass for squared deviations
        S_DIVM: begin
          if (dcnt_r == '0) begin
            mean_r  <= neg_r ? -dq_r[15:0] : dq_r[15:0];
            pass_r  <= 1'b1;
            wa_r    <= WAW'(fc_r);
            state_r <= S_SCAN;
          end
        end

        // variance done; start the root
        S_DIVV: begin
          if (dcnt_r == '0) begin
            sv_r    <= 34'(dq_r[31:0]);
            sres_r  <= '0;
            sbit_r  <= 34'(1) << 30;
            state_r <= S_SQRT;
          end
        end

        // floor square root, one bit pair a cycle
        S_SQRT: begin
          if (sbit_r == '0) begin
            off_r   <= mean_r;
            scl_r   <= sres_r[15:0];
            state_r <= S_COLWR;
          end else begin
            if (sv_r >= s_trial) begin
              sv_r   <= sv_r - s_trial;
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end

        // column stats written; next column or done
        S_COLWR: begin
          if (CEW'(fc_r) == cols - CEW'(1)) begin
            ready_r <= 1'b1;
            pos_r   <= '0;
            rcol_r  <= '0;
            pres_r  <= '0;
            plast_r <= 1'b0;
            pstat_r <= fcn_pkg::ST_OK;
            state_r <= S_RESP;
          end else begin
            fc_r    <= fc_r + CLW'(1);
            wa_r    <= WAW'(fc_r) + WAW'(1);
            pass_r  <= 1'b0;
            first_r <= 1'b1;
            sum_r   <= '0;
            sq_r    <= '0;
            state_r <= S_SCAN;
          end
        end

        // element and column stats are out of memory
        S_RD1: begin
          if (rscl == '0) begin
            pres_r  <= rx;
            state_r <= S_RESP;
          end else begin
            neg_r   <= rdiff[16];
            dq_r    <= DW'({rmag, 8'd0}) << (DW - RNW);
            drem_r  <= '0;
            dden_r  <= DV'(rscl);
            dcnt_r  <= DCW'(RNW);
            state_r <= S_RDIV;
          end
        end

        // quotient with sign and saturation
        S_RDIV: begin
          if (dcnt_r == '0) begin
            if (!neg_r) begin
              pres_r <= (dq_r > DW'(32767)) ? 16'sh7FFF : dq_r[15:0];
            end else begin
              pres_r <= (dq_r > DW'(32768)) ? 16'sh8000 : -dq_r[15:0];
            end
            state_r <= S_RESP;
          end
        end

        // hand the result to the output register
        S_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{result_value: pres_r, is_last: plast_r, status: pstat_r};
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/fcn_checker.sv
// port-level checker for the column normalizer and its bind
module fcn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input fcn_pkg::out_t                  out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // failed requests carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fcn_pkg::ST_OK |-> out_data.result_value == '0)
    else $error("nonzero value with error status");

  // last flag only on a good read
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_last |-> out_data.status == fcn_pkg::ST_OK)
    else $error("last flag with error status");

  // a request is not taken while a stalled result waits
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result blocked");

endmodule

bind feature_column_normalizer_unit fcn_checker u_fcn_checker (.*);

FILE: test/feature_column_normalizer_unit_tb.sv
// testbench for the column normalizer: directed table and random matrices
`timescale 1ns / 100ps

module feature_column_normalizer_unit_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fcn_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fcn_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [fcn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fcn_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  feature_column_normalizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] store_mem [0:fcn_pkg::STORE_DEPTH_DEF-1];
  int unsigned elem_count = 0;
  int unsigned rd_pos = 0;
  int col_offset [0:fcn_pkg::MAX_COLUMNS_DEF-1];
  int col_scale [0:fcn_pkg::MAX_COLUMNS_DEF-1];
  bit stats_ok = 0;
  logic [4:0] ncols_reg = 5'd1;
  logic mode_reg = fcn_pkg::MODE_ZSCORE;

  fcn_pkg::out_t expected_results [$];
  bit typed_valid = 0;
  fcn_pkg::out_t typed_exp;
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int burst_left = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;

  function automatic int unsigned active_cols();
    if (ncols_reg == 0) return 1;
    if (ncols_reg > fcn_pkg::MAX_COLUMNS_DEF) return fcn_pkg::MAX_COLUMNS_DEF;
    return ncols_reg;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // per-column offset and scale over the stored matrix
  task automatic column_stats(int unsigned cols, int unsigned rows);
    longint sum;
    longint mean;
    longint sq;
    longint d;
    int lo;
    int hi;
    for (int c = 0; c < cols; c++) begin
      if (mode_reg == fcn_pkg::MODE_ZSCORE) begin
        sum = 0;
        sq = 0;
        for (int r = 0; r < rows; r++) sum += store_mem[r * cols + c];
        mean = sum / longint'(rows);
        for (int r = 0; r < rows; r++) begin
          d = longint'(store_mem[r * cols + c]) - mean;
          sq += d * d;
        end
        col_offset[c] = int'(mean);
        col_scale[c] = int'(floor_sqrt(sq / longint'(rows)));
      end else begin
        lo = store_mem[c];
        hi = store_mem[c];
        for (int r = 1; r < rows; r++) begin
          if (store_mem[r * cols + c] < lo) lo = store_mem[r * cols + c];
          if (store_mem[r * cols + c] > hi) hi = store_mem[r * cols + c];
        end
        col_offset[c] = lo;
        col_scale[c] = hi - lo;
      end
    end
  endtask

  // one request through the normalizer state, returns the result it yields
  task automatic normalize_request(input fcn_pkg::in_t rq, output fcn_pkg::out_t rs);
    int unsigned cols;
    int x;
    int unsigned c;
    longint q;
    cols = active_cols();
    rs = '0;
    case (rq.cmd)
      fcn_pkg::CMD_LOAD: begin
        if (elem_count >= fcn_pkg::STORE_DEPTH_DEF) begin
          rs.status = fcn_pkg::ST_FULL;
        end else begin
          store_mem[elem_count] = rq.sample_value;
          elem_count++;
          stats_ok = 0;
        end
      end
      fcn_pkg::CMD_FINISH: begin
        if (elem_count == 0 || elem_count % cols != 0) begin
          rs.status = fcn_pkg::ST_BAD_SHAPE;
          stats_ok = 0;
        end else begin
          column_stats(cols, elem_count / cols);
          stats_ok = 1;
          rd_pos = 0;
        end
      end
      fcn_pkg::CMD_READ: begin
        if (!stats_ok || elem_count == 0 || rd_pos >= elem_count) begin
          rs.status = fcn_pkg::ST_NOT_READY;
        end else begin
          x = store_mem[rd_pos];
          c = rd_pos % cols;
          if (col_scale[c] == 0) begin
            q = x;
          end else begin
            q = (longint'(x) - longint'(col_offset[c])) * 256 / longint'(col_scale[c]);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
          end
          rs.result_value = q[15:0];
          if (rd_pos + 1 >= elem_count) begin
            rs.is_last = 1'b1;
            rd_pos = 0;
          end else begin
            rd_pos++;
          end
        end
      end
      default: begin
        elem_count = 0;
        rd_pos = 0;
        stats_ok = 0;
      end
    endcase
  endtask

  // request and result monitors, sampled mid-cycle where nothing moves
  always @(negedge clk) begin
    fcn_pkg::out_t pred;
    fcn_pkg::out_t want;
    if (rst_n && in_valid && !in_stall) begin
      normalize_request(in_data, pred);
      expected_results.insert(expected_results.size(), typed_valid ? typed_exp : pred);
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_value !== want.result_value || out_data.is_last !== want.is_last
            || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d last %0b status %0d, got %0d %0b %0d",
                     want.result_value, want.is_last, want.status,
                     out_data.result_value, out_data.is_last, out_data.status);
        end
      end
    end
  end

  // receiver stall pattern with an optional long hold-off
  always @(posedge clk) begin
    stall_cyc++;
    if (stall_cyc % 256 == 0) stall_mode = $urandom % 3;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom % 4 == 0);
        default: out_stall <= (stall_cyc % 9) >= 6;
      endcase
    end
  end

  // send one request in a burst, gaps between bursts
  task automatic send_request(input fcn_pkg::in_t rq);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    burst_left--;
    requests_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] val);
    fcn_pkg::in_t rq;
    rq.cmd = cmd;
    rq.sample_value = val;
    send_request(rq);
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fcn_pkg::CFG_IDX_W-1:0] idx, input logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == fcn_pkg::REG_COLUMN_COUNT) ncols_reg = val;
    else mode_reg = val[0];
    stats_ok = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // directed table
  typedef struct {
    bit is_cfg;
    logic [fcn_pkg::CFG_IDX_W-1:0] idx;
    logic [4:0] val;
    fcn_pkg::in_t rq;
    bit typed;
    fcn_pkg::out_t exp;
  } dir_row_t;

  function automatic dir_row_t row_cfg(logic [fcn_pkg::CFG_IDX_W-1:0] idx, logic [4:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t row_req(logic [1:0] cmd, logic [15:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.rq.cmd = cmd;
    r.rq.sample_value = val;
    return r;
  endfunction

  function automatic dir_row_t row_chk(logic [1:0] cmd, logic [15:0] val, logic [1:0] st);
    dir_row_t r;
    r = row_req(cmd, val);
    r.typed = 1;
    r.exp.status = st;
    return r;
  endfunction

  dir_row_t dir_rows [$];

  function automatic logic [15:0] pick_sample(int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 128) - 64);
      2: return 16'h0123;
      default: return ($urandom % 3 == 0) ? 16'h8000 : (($urandom % 2) ? 16'h7fff : 16'($urandom));
    endcase
  endfunction

  initial begin
    int unsigned cols;
    int unsigned rows;
    int style;
    int reads;
    int seq_no;
    logic [4:0] cc_pick [6];
    cc_pick = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd3};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, every command, shapes, config side effects
    dir_rows = {
      row_chk(fcn_pkg::CMD_READ, 16'h0, fcn_pkg::ST_NOT_READY),
      row_chk(fcn_pkg::CMD_FINISH, 16'h0, fcn_pkg::ST_BAD_SHAPE),
      row_chk(fcn_pkg::CMD_LOAD, 16'h7fff, fcn_pkg::ST_OK),
      row_chk(fcn_pkg::CMD_LOAD, 16'h8000, fcn_pkg::ST_OK),
      row_chk(fcn_pkg::CMD_FINISH, 16'h0, fcn_pkg::ST_OK),
      row_req(fcn_pkg::CMD_READ, 16'h0), row_req(fcn_pkg::CMD_READ, 16'h0),
      row_req(fcn_pkg::CMD_READ, 16'h0),
      row_cfg(fcn_pkg::REG_COLUMN_COUNT, 5'd0),
      row_chk(fcn_pkg::CMD_READ, 16'h0, fcn_pkg::ST_NOT_READY),
      row_chk(fcn_pkg::CMD_FINISH, 16'h0, fcn_pkg::ST_OK),
      row_req(fcn_pkg::CMD_READ, 16'h0),
      row_chk(fcn_pkg::CMD_CLEAR, 16'hffff, fcn_pkg::ST_OK),
      row_cfg(fcn_pkg::REG_COLUMN_COUNT, 5'd3), row_cfg(fcn_pkg::REG_NORM_MODE, 5'd1),
      row_req(fcn_pkg::CMD_LOAD, 16'h0100), row_req(fcn_pkg::CMD_LOAD, 16'hfffb),
      row_chk(fcn_pkg::CMD_FINISH, 16'h0, fcn_pkg::ST_BAD_SHAPE),
      row_req(fcn_pkg::CMD_LOAD, 16'h0007), row_req(fcn_pkg::CMD_LOAD, 16'h0007),
      row_req(fcn_pkg::CMD_LOAD, 16'h0007), row_req(fcn_pkg::CMD_LOAD, 16'h8000),
      row_chk(fcn_pkg::CMD_FINISH, 16'h0, fcn_pkg::ST_OK),
      row_req(fcn_pkg::CMD_READ, 16'h0), row_req(fcn_pkg::CMD_READ, 16'h0),
      row_chk(fcn_pkg::CMD_LOAD, 16'h0001, fcn_pkg::ST_OK),
      row_chk(fcn_pkg::CMD_READ, 16'h0, fcn_pkg::ST_NOT_READY)
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        typed_valid = dir_rows[i].typed;
        typed_exp = dir_rows[i].exp;
        send_request(dir_rows[i].rq);
        typed_valid = 0;
      end
    end

    // random matrices: mostly well-formed load/finish/read runs, some noise
    seq_no = 0;
    while (requests_sent < 720) begin
      drain();
      write_reg(fcn_pkg::REG_COLUMN_COUNT, ($urandom % 2) ? cc_pick[$urandom % 6]
                                                          : 5'($urandom_range(1, 16)));
      if ($urandom % 2) write_reg(fcn_pkg::REG_NORM_MODE, 5'($urandom % 2));
      if (seq_no == 3) hold_left = 400;
      seq_no++;
      cols = active_cols();
      rows = $urandom_range(1, 6);
      style = $urandom % 4;
      if ($urandom % 4 == 0) send_cmd(fcn_pkg::CMD_CLEAR, 16'($urandom));
      for (int i = 0; i < rows * cols; i++) begin
        if ($urandom % 12 == 0) send_cmd(2'($urandom), 16'($urandom));
        send_cmd(fcn_pkg::CMD_LOAD, pick_sample(style));
      end
      send_cmd(fcn_pkg::CMD_FINISH, 16'($urandom));
      reads = elem_count + $urandom_range(0, 3);
      if (reads > 40) reads = 40;
      for (int i = 0; i < reads; i++) send_cmd(fcn_pkg::CMD_READ, 16'($urandom));
      if ($urandom % 6 == 0) begin
        send_cmd(fcn_pkg::CMD_LOAD, 16'($urandom));
        send_cmd(fcn_pkg::CMD_READ, 16'($urandom));
      end
      if ($urandom % 5 == 0) send_cmd(fcn_pkg::CMD_CLEAR, 16'($urandom));
    end

    drain();
    repeat (50) @(posedge clk);
    $display("ran %0d requests, %0d results checked, over column counts 0..31,",
             requests_sent, results_seen);
    $display("both modes, bad shapes, zero scales and wrap-around reads");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
